@@ sv/fwpu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpu_pkg
// Shared types and constants of the firmware packet uploader.
// ----------------------------------------------------------------------------
package fwpu_pkg;

  // field widths
  localparam int COUNT_W = 14;
  localparam int RETRY_W = 4;
  localparam int BYTE_W  = 8;
  localparam int ACT_W   = 3;
  localparam int CFG_IDX_W = 1;

  // defaults and limits
  localparam int PACKET_BYTES_DEF = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [RETRY_W-1:0] RETRY_MAX   = '1;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd10;
  localparam logic [BYTE_W-1:0]  COMMIT_OK   = 8'd1;

  // input word kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE      = 3'd0,
    ACT_COMMIT_REQ = 3'd1,
    ACT_COMMITTED  = 3'd2,
    ACT_DONE       = 3'd3,
    ACT_FAILED     = 3'd4
  } action_t;

  // source of the byte field of an output word
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_DATA = 2'd1,
    SEL_CSUM = 2'd2,
    SEL_BUF  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      store_byte;
    logic      commit_pkt;
    logic      fail_pkt;
    logic      replay_start;
    logic      replay_step;
    logic      emit;
    action_t   emit_action;
    byte_sel_t emit_sel;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic reached_total;
    logic fail_limit_hit;
    logic pkt_full;
    logic replay_end;
  } dp_status_t;

endpackage

@@ sv/fwpu_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpu_dp
// Datapath: config registers, packet buffer, sum and counters, output word.
// ----------------------------------------------------------------------------
module fwpu_dp import fwpu_pkg::*; #(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [ACT_W-1:0]     out_action,
  output logic [BYTE_W-1:0]    out_write_byte,
  output logic [COUNT_W-1:0]   out_flashed_count,
  output logic                 out_last
);

  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [CW-1:0]      FILL_FULL = CW'(PACKET_BYTES);
  localparam logic [AW-1:0]      REP_END   = AW'(PACKET_BYTES - 1);
  localparam logic [COUNT_W:0]   PKT_ADD   = (COUNT_W + 1)'(PACKET_BYTES);

  logic [COUNT_W-1:0] total_r;
  logic [RETRY_W-1:0] retry_r;
  logic [BYTE_W-1:0]  buf_mem [PACKET_BYTES];
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [RETRY_W-1:0] failed_r, failed_nxt, failed_inc;
  logic [COUNT_W-1:0] committed_r, committed_nxt, committed_add;
  logic [COUNT_W:0]   committed_wide;
  logic [AW-1:0]      rep_r, rep_nxt;
  logic [BYTE_W-1:0]  data_r;
  logic [BYTE_W-1:0]  byte_mux;

  logic               out_valid_r;
  logic [ACT_W-1:0]   out_action_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      retry_r <= RETRY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TOTAL_BYTES: total_r <= cfg_wdata;
        CFG_RETRY_LIMIT: retry_r <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating count updates
  assign committed_wide = {1'b0, committed_r} + PKT_ADD;
  assign committed_add  = (committed_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                               : committed_wide[COUNT_W-1:0];
  assign failed_inc     = (failed_r == RETRY_MAX) ? RETRY_MAX : failed_r + 1'b1;

  // packet state next values
  always_comb begin
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    failed_nxt    = failed_r;
    committed_nxt = committed_r;
    rep_nxt       = rep_r;
    if (cmd.store_byte) begin
      sum_nxt  = sum_r + in_data_byte;
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.commit_pkt) begin
      sum_nxt       = '0;
      fill_nxt      = '0;
      failed_nxt    = '0;
      committed_nxt = committed_add;
    end
    if (cmd.fail_pkt) begin
      failed_nxt = failed_inc;
    end
    if (cmd.replay_start) begin
      rep_nxt = '0;
    end else if (cmd.replay_step) begin
      rep_nxt = rep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      fill_r      <= '0;
      failed_r    <= '0;
      committed_r <= '0;
      rep_r       <= '0;
    end else begin
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      failed_r    <= failed_nxt;
      committed_r <= committed_nxt;
      rep_r       <= rep_nxt;
    end
  end

  // packet buffer and latched data byte
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      buf_mem[fill_r[AW-1:0]] <= in_data_byte;
      data_r                  <= in_data_byte;
    end
  end

  // status back to the controller
  assign st.out_free       = !out_valid_r || out_ready;
  assign st.reached_total  = committed_r >= total_r;
  assign st.fail_limit_hit = failed_inc >= retry_r;
  assign st.pkt_full       = fill_r >= FILL_FULL;
  assign st.replay_end     = rep_r == REP_END;

  // byte field selection, buffer bytes are read in the output register
  always_comb begin
    unique case (cmd.emit_sel)
      SEL_DATA: byte_mux = data_r;
      SEL_CSUM: byte_mux = (sum_r ^ 8'hFF) + 1'b1;
      default:  byte_mux = '0;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_action_r <= cmd.emit_action;
      out_byte_r   <= (cmd.emit_sel == SEL_BUF) ? buf_mem[rep_r] : byte_mux;
      out_count_r  <= committed_r;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_write_byte    = out_byte_r;
  assign out_flashed_count = out_count_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  // a new word is only loaded when the output slot can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free) else $error("word emitted over a pending word");

  // fill count never runs past one packet
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL) else $error("fill count overflow");

  // a committed packet restarts collection from an empty sum
  a_commit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_pkt |=> (fill_r == '0 && sum_r == '0 && failed_r == '0))
    else $error("packet state not cleared on commit");

  // bytes are only stored into a packet that is not yet full
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_byte |-> !st.pkt_full) else $error("byte stored into full packet");
`endif

endmodule

@@ sv/fwpu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpu_ctrl
// Controller: decides on each input word and sequences the output words.
// ----------------------------------------------------------------------------
module fwpu_ctrl import fwpu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [BYTE_W-1:0] in_commit_value,
  input  dp_status_t        st,
  output dp_cmd_t           cmd
);

  typedef enum logic [8:0] {
    S_COLLECT   = 9'b000000001,
    S_AWAIT     = 9'b000000010,
    S_DATA      = 9'b000000100,
    S_CSUM      = 9'b000001000,
    S_REQ       = 9'b000010000,
    S_COMMITTED = 9'b000100000,
    S_DONE      = 9'b001000000,
    S_FAILED    = 9'b010000000,
    S_REPLAY    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    in_ready  = 1'b0;
    cmd       = '0;
    if (fin_r) begin
      // finished: words are taken and dropped until reset
      in_ready = 1'b1;
    end else begin
      unique case (state_r)
        S_COLLECT: begin
          in_ready = 1'b1;
          if (in_valid && in_kind == KIND_DATA) begin
            if (st.reached_total) begin
              state_nxt = S_DONE;
            end else begin
              cmd.store_byte = 1'b1;
              state_nxt      = S_DATA;
            end
          end
        end
        S_AWAIT: begin
          in_ready = 1'b1;
          if (in_valid && in_kind == KIND_RESP) begin
            if (in_commit_value == COMMIT_OK) begin
              cmd.commit_pkt = 1'b1;
              state_nxt      = S_COMMITTED;
            end else begin
              cmd.fail_pkt = 1'b1;
              if (st.fail_limit_hit) begin
                state_nxt = S_FAILED;
              end else begin
                cmd.replay_start = 1'b1;
                state_nxt        = S_REPLAY;
              end
            end
          end
        end
        S_DATA: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_WRITE;
            cmd.emit_sel    = SEL_DATA;
            cmd.emit_last   = !st.pkt_full;
            state_nxt       = st.pkt_full ? S_CSUM : S_COLLECT;
          end
        end
        S_REPLAY: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_WRITE;
            cmd.emit_sel    = SEL_BUF;
            cmd.replay_step = 1'b1;
            if (st.replay_end) begin
              state_nxt = S_CSUM;
            end
          end
        end
        S_CSUM: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_WRITE;
            cmd.emit_sel    = SEL_CSUM;
            state_nxt       = S_REQ;
          end
        end
        S_REQ: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_COMMIT_REQ;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_AWAIT;
          end
        end
        S_COMMITTED: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_COMMITTED;
            cmd.emit_last   = !st.reached_total;
            state_nxt       = st.reached_total ? S_DONE : S_COLLECT;
          end
        end
        S_DONE: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_DONE;
            cmd.emit_last   = 1'b1;
            fin_nxt         = 1'b1;
          end
        end
        S_FAILED: begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_action = ACT_FAILED;
            cmd.emit_last   = 1'b1;
            fin_nxt         = 1'b1;
          end
        end
        default: begin
          state_nxt = S_COLLECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ sv/firmware_packet_uploader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_packet_uploader
// Forwards image bytes as upload writes in checksummed, committed packets.
// ----------------------------------------------------------------------------
// One input word is handled at a time; each output word waits in the output
// register until out_ready is high. A data byte is accepted, then its write
// word is sent; when it closes a packet, the checksum and commit request
// follow. A failed commit replays the buffer one byte per cycle while the
// output register is free, then the checksum and commit request. The
// controller emits one word per free cycle via the single output register;
// the next input word is accepted while the last output word still waits.
module firmware_packet_uploader import fwpu_pkg::*; #(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic [BYTE_W-1:0]    in_commit_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ACT_W-1:0]     out_action,
  output logic [BYTE_W-1:0]    out_write_byte,
  output logic [COUNT_W-1:0]   out_flashed_count,
  output logic                 out_last
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencing
  fwpu_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_commit_value (in_commit_value),
    .st              (st),
    .cmd             (cmd)
  );

  // storage and output word
  fwpu_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_data_byte      (in_data_byte),
    .cmd               (cmd),
    .st                (st),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_action        (out_action),
    .out_write_byte    (out_write_byte),
    .out_flashed_count (out_flashed_count),
    .out_last          (out_last)
  );

endmodule

@@ dv/tb_firmware_packet_uploader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_firmware_packet_uploader
// Self-checking bench for the firmware packet uploader. Image bytes and
// commit responses are pushed through the input handshake. Every accepted
// word updates a behavioral copy of the uploader, and that copy queues the
// output words it should cause. Each output word is checked field by field
// against the oldest queued one. Both handshakes idle in random bursts.
// Configuration changes only land while nothing is in flight. The update
// ends the run in a done or a failed state, and the seed picks which one.
// ----------------------------------------------------------------------------
module tb_firmware_packet_uploader;
  import fwpu_pkg::*;

  localparam int PKT         = PACKET_BYTES_DEF;
  localparam int SETTLE      = PKT + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_WORDS = 200;
  localparam logic [BYTE_W-1:0] EDGE_BYTES [8] =
    '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'hFF};

  typedef enum logic [1:0] {
    ST_COLLECT, ST_AWAIT, ST_DONE, ST_FAILED
  } stage_t;

  typedef struct {
    action_t             action;
    logic [BYTE_W-1:0]   wbyte;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } upload_word_t;

  // behavioral copy of the uploader plus the queue of words it owes
  class packet_tracker;
    logic [COUNT_W-1:0] total_bytes;
    logic [RETRY_W-1:0] retry_limit;
    logic [BYTE_W-1:0]  pkt_bytes [PKT];
    logic [BYTE_W-1:0]  pkt_sum;
    int                 fill;
    logic [RETRY_W-1:0] fails;
    logic [COUNT_W-1:0] committed;
    stage_t             stage;
    upload_word_t       pending_words [$];
    int                 errors;

    function new();
      total_bytes = '0;
      retry_limit = RETRY_RESET;
      pkt_sum     = '0;
      fill        = 0;
      fails       = '0;
      committed   = '0;
      stage       = ST_COLLECT;
      errors      = 0;
      foreach (pkt_bytes[i]) pkt_bytes[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] value);
      if (idx == CFG_TOTAL_BYTES) total_bytes = value;
      else retry_limit = value[RETRY_W-1:0];
    endfunction

    function void push(action_t act, logic [BYTE_W-1:0] b);
      upload_word_t w;
      w.action = act;
      w.wbyte  = b;
      w.count  = committed;
      w.last   = 1'b0;
      pending_words.push_back(w);
    endfunction

    // checksum write then commit request
    function void push_trailer();
      logic [BYTE_W-1:0] csum;
      csum = ~pkt_sum + 8'd1;
      push(ACT_WRITE, csum);
      push(ACT_COMMIT_REQ, '0);
    endfunction

    function void note_word(logic kind, logic [BYTE_W-1:0] data,
                            logic [BYTE_W-1:0] commit);
      int first;
      int grown;
      first = pending_words.size();
      if (stage == ST_COLLECT && kind == KIND_DATA) begin
        // nothing left to flash ends the update
        if (committed >= total_bytes) begin
          stage = ST_DONE;
          push(ACT_DONE, '0);
        end else begin
          pkt_bytes[fill] = data;
          pkt_sum = pkt_sum + data;
          fill++;
          push(ACT_WRITE, data);
          if (fill >= PKT) begin
            push_trailer();
            stage = ST_AWAIT;
          end
        end
      end else if (stage == ST_AWAIT && kind == KIND_RESP) begin
        if (commit == COMMIT_OK) begin
          grown = int'(committed) + PKT;
          committed = (grown > int'(COUNT_MAX)) ? COUNT_MAX : grown[COUNT_W-1:0];
          fails   = '0;
          fill    = 0;
          pkt_sum = '0;
          push(ACT_COMMITTED, '0);
          if (committed >= total_bytes) begin
            stage = ST_DONE;
            push(ACT_DONE, '0);
          end else begin
            stage = ST_COLLECT;
          end
        end else begin
          // failed commit: give up at the limit, else replay the packet
          if (fails != RETRY_MAX) fails++;
          if (fails >= retry_limit) begin
            stage = ST_FAILED;
            push(ACT_FAILED, '0);
          end else begin
            foreach (pkt_bytes[i]) push(ACT_WRITE, pkt_bytes[i]);
            push_trailer();
          end
        end
      end
      if (pending_words.size() > first)
        pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    function void check_word(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
                             logic [COUNT_W-1:0] cnt, logic last);
      upload_word_t w;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: action %0d byte %0h count %0d last %0b",
                 $time, act, b, cnt, last);
      end else begin
        w = pending_words.pop_front();
        if (act !== w.action) begin
          errors++;
          $display("%0t: action expected %0d actual %0d", $time, w.action, act);
        end
        if (b !== w.wbyte) begin
          errors++;
          $display("%0t: write_byte expected %0h actual %0h", $time, w.wbyte, b);
        end
        if (cnt !== w.count) begin
          errors++;
          $display("%0t: flashed_count expected %0d actual %0d", $time, w.count, cnt);
        end
        if (last !== w.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, w.last, last);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_TOTAL_BYTES;
  logic [COUNT_W-1:0]   cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic                 in_kind         = KIND_DATA;
  logic [BYTE_W-1:0]    in_data_byte    = '0;
  logic [BYTE_W-1:0]    in_commit_value = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [ACT_W-1:0]     out_action;
  logic [BYTE_W-1:0]    out_write_byte;
  logic [COUNT_W-1:0]   out_flashed_count;
  logic                 out_last;

  packet_tracker tracker = new();
  bit            no_idle = 1'b0;
  bit            stall_on = 1'b1;
  int            stall_left = 0;
  int            random_words = 0;
  int            cycles = 0;

  firmware_packet_uploader #(.PACKET_BYTES(PKT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .in_commit_value  (in_commit_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_write_byte   (out_write_byte),
    .out_flashed_count(out_flashed_count),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_firmware_packet_uploader: done, errors");
      $finish;
    end
  end

  // output side: random stall bursts, none at the end
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!no_idle && stall_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) stall_on = 1'($urandom_range(0, 1));
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_word(out_action, out_write_byte, out_flashed_count, out_last);
  end

  task automatic send_word(input logic kind, input logic [BYTE_W-1:0] data,
                           input logic [BYTE_W-1:0] commit);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_data_byte    <= data;
    in_commit_value <= commit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_word(kind, data, commit);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic idle_gap(input bit quiet);
    if (!no_idle && !quiet && $urandom_range(0, 3) == 0)
      hold_off($urandom_range(1, 19));
  endtask

  // wait until every owed word is out, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // upper bits of the write data are junk for the retry register
  task automatic set_retry(input logic [RETRY_W-1:0] limit);
    logic [COUNT_W-1:0] w;
    w = COUNT_W'($urandom);
    w[RETRY_W-1:0] = limit;
    write_reg(CFG_RETRY_LIMIT, w);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: pick_byte = 8'h00;
      1: pick_byte = 8'hFF;
      default: pick_byte = BYTE_W'($urandom);
    endcase
  endfunction

  // one packet with random content, stray words and commit outcomes
  task automatic run_packet(input bit force_fail);
    bit                quiet;
    logic [BYTE_W-1:0] resp;
    quiet = ($urandom_range(0, 3) == 0);
    while (tracker.stage == ST_COLLECT) begin
      if ($urandom_range(0, 9) == 0)
        send_word(KIND_RESP, BYTE_W'($urandom), BYTE_W'($urandom));
      idle_gap(quiet);
      send_word(KIND_DATA, pick_byte(), BYTE_W'($urandom));
      random_words++;
    end
    while (tracker.stage == ST_AWAIT) begin
      if ($urandom_range(0, 9) == 0)
        send_word(KIND_DATA, BYTE_W'($urandom), BYTE_W'($urandom));
      idle_gap(quiet);
      if (force_fail ||
          (tracker.fails + 1 < tracker.retry_limit && $urandom_range(0, 2) == 0)) begin
        do resp = BYTE_W'($urandom); while (resp == COMMIT_OK);
      end else begin
        resp = COMMIT_OK;
      end
      send_word(KIND_RESP, BYTE_W'($urandom), resp);
      random_words++;
    end
  endtask

  initial begin
    int ending;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_TOTAL_BYTES, 14'd8192);
    set_retry(4'd15);

    // response while collecting is dropped
    send_word(KIND_RESP, BYTE_W'($urandom), COMMIT_OK);
    for (int i = 0; i < PKT; i++)
      send_word(KIND_DATA, EDGE_BYTES[i % 8], BYTE_W'($urandom));
    // data byte while awaiting the commit is dropped
    send_word(KIND_DATA, 8'h5A, BYTE_W'($urandom));
    send_word(KIND_RESP, BYTE_W'($urandom), 8'h00);
    send_word(KIND_RESP, BYTE_W'($urandom), 8'hFF);
    send_word(KIND_RESP, BYTE_W'($urandom), 8'h02);
    send_word(KIND_RESP, BYTE_W'($urandom), COMMIT_OK);
    settle();

    // lowest retry limit while no commit can fail, sum wraps
    set_retry(4'd1);
    for (int i = 0; i < PKT; i++)
      send_word(KIND_DATA, 8'hFF, BYTE_W'($urandom));
    settle();

    // zero total only matters at the next commit, a replay comes first
    set_retry(4'd15);
    write_reg(CFG_TOTAL_BYTES, '0);
    send_word(KIND_RESP, BYTE_W'($urandom), 8'h81);
    settle();
    write_reg(CFG_TOTAL_BYTES, 14'd8192);
    send_word(KIND_RESP, BYTE_W'($urandom), COMMIT_OK);

    // random packets, with idle pauses and register changes between them
    while (random_words < RANDOM_WORDS) begin
      run_packet(1'b0);
      if ($urandom_range(0, 5) == 0) begin
        settle();
        if ($urandom_range(0, 1)) set_retry(RETRY_W'($urandom_range(2, 15)));
        if ($urandom_range(0, 1))
          write_reg(CFG_TOTAL_BYTES,
                    COUNT_W'($urandom_range(tracker.committed + 400, 8192)));
      end
    end

    // closing part: no idling, end in done or failed
    no_idle = 1'b1;
    settle();
    ending = $urandom_range(0, 2);
    case (ending)
      0: begin
        write_reg(CFG_TOTAL_BYTES, COUNT_W'(tracker.committed + 2 * PKT));
        while (tracker.stage != ST_DONE) run_packet(1'b0);
      end
      1: begin
        write_reg(CFG_TOTAL_BYTES, '0);
        send_word(KIND_DATA, BYTE_W'($urandom), BYTE_W'($urandom));
      end
      default: begin
        set_retry(RETRY_W'($urandom_range(0, 1)));
        run_packet(1'b1);
      end
    endcase

    // finished: everything is dropped
    repeat (4)
      send_word(1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    settle();

    if (tracker.errors == 0) begin
      $display("tb_firmware_packet_uploader: done, clean");
    end else begin
      $display("tb_firmware_packet_uploader: done, errors");
    end
    $finish;
  end

endmodule

@@ firmware_packet_uploader.f @@
sv/fwpu_pkg.sv
sv/fwpu_dp.sv
sv/fwpu_ctrl.sv
sv/firmware_packet_uploader.sv
dv/tb_firmware_packet_uploader.sv
